### design/stlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlf_pkg
// Shared constants, types and address helpers of the set-associative tag
// lookup engine with FIFO replacement.
// ----------------------------------------------------------------------------
package stlf_pkg;

    // Address layout: offset, then set index, then tag.
    localparam int ADDR_W      = 32;
    localparam int OFFSET_BITS = 6;
    localparam int SET_BITS    = 6;
    localparam int SETS        = 1 << SET_BITS;
    localparam int WAYS        = 16;
    localparam int TAG_W       = 20;
    localparam int AGE_W       = 5;
    localparam int WAY_W       = 4;
    localparam int WAY_IDX_W   = $clog2(WAYS);
    localparam int CNT_W       = $clog2(WAYS + 1);
    localparam int ENTRY_W     = SET_BITS + WAY_IDX_W;
    localparam int ENTRIES     = SETS << WAY_IDX_W;
    localparam int TAG_LSB     = OFFSET_BITS + SET_BITS;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [SET_BITS-1:0]  set_idx_t;
    typedef logic [WAY_IDX_W-1:0] way_idx_t;
    typedef logic [WAY_W-1:0]     way_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [ENTRY_W-1:0]   entry_t;
    typedef logic [TAG_W-1:0]     tag_t;
    typedef logic [AGE_W-1:0]     age_t;
    typedef logic [WAYS-1:0]      row_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_AGE,
        ST_RESP
    } state_t;

    // One way of the set as it comes out of the tag and age memories.
    typedef struct packed {
        logic     en;
        way_idx_t way;
        logic     line_valid;
        tag_t     tag;
        age_t     age;
    } scan_step_t;

    // Summary of a whole set after the scan.
    typedef struct packed {
        logic     hit;
        way_idx_t hit_way;
        logic     inv_found;
        way_idx_t inv_way;
        way_idx_t min_way;
        tag_t     min_tag;
    } scan_res_t;

    // Set index: low bits of the line number.
    function automatic set_idx_t addr_set(input addr_t addr);
        return addr[OFFSET_BITS +: SET_BITS];
    endfunction

    // Tag: line number above the set index, zero filled past the address top.
    function automatic tag_t addr_tag(input addr_t addr);
        logic [ADDR_W+TAG_W-1:0] ext;
        ext = {{TAG_W{1'b0}}, addr};
        return ext[TAG_LSB +: TAG_W];
    endfunction

endpackage

### design/stlf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module stlf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/stlf_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlf_scan
// Shared compare unit. Takes one way per cycle and accumulates the hit way,
// the first invalid way and the oldest way of the set.
// ----------------------------------------------------------------------------
module stlf_scan (
    input  logic                aclk,
    input  stlf_pkg::scan_step_t step,
    input  stlf_pkg::tag_t      key_tag,
    output stlf_pkg::scan_res_t res
);

    logic               hit_reg, hit_next;
    stlf_pkg::way_idx_t hit_way_reg, hit_way_next;
    logic               inv_reg, inv_next;
    stlf_pkg::way_idx_t inv_way_reg, inv_way_next;
    stlf_pkg::age_t     min_age_reg, min_age_next;
    stlf_pkg::way_idx_t min_way_reg, min_way_next;
    stlf_pkg::tag_t     min_tag_reg, min_tag_next;

    logic first;
    logic match;
    logic age_lt;

    // One tag comparator and one age comparator serve every way in turn.
    assign first  = (step.way == '0);
    assign match  = step.line_valid && (step.tag == key_tag);
    assign age_lt = (step.age < min_age_reg);

    // Accumulators restart on way zero; ties keep the lower way.
    always_comb begin
        hit_next     = hit_reg;
        hit_way_next = hit_way_reg;
        inv_next     = inv_reg;
        inv_way_next = inv_way_reg;
        min_age_next = min_age_reg;
        min_way_next = min_way_reg;
        min_tag_next = min_tag_reg;
        if (step.en) begin
            if (first) begin
                hit_next = match;
                inv_next = !step.line_valid;
            end else begin
                hit_next = hit_reg || match;
                inv_next = inv_reg || !step.line_valid;
            end
            if (match && (first || !hit_reg)) begin
                hit_way_next = step.way;
            end
            if (!step.line_valid && (first || !inv_reg)) begin
                inv_way_next = step.way;
            end
            if (first || age_lt) begin
                min_age_next = step.age;
                min_way_next = step.way;
                min_tag_next = step.tag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg     <= hit_next;
        hit_way_reg <= hit_way_next;
        inv_reg     <= inv_next;
        inv_way_reg <= inv_way_next;
        min_age_reg <= min_age_next;
        min_way_reg <= min_way_next;
        min_tag_reg <= min_tag_next;
    end

    assign res.hit       = hit_reg;
    assign res.hit_way   = hit_way_reg;
    assign res.inv_found = inv_reg;
    assign res.inv_way   = inv_way_reg;
    assign res.min_way   = min_way_reg;
    assign res.min_tag   = min_tag_reg;

endmodule

### design/set_assoc_tag_lookup_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_tag_lookup_fifo_core
// Tag lookup and FIFO replacement engine of a set-associative cache.
//
// The s_ channel carries one physical byte address per transfer. The m_
// channel returns one result per address: hit, the way that hit or was
// allocated, and on a miss in a full set the evicted flag and old tag.
// A single sequencer drives one compare unit over the ways of the set, one
// way per cycle, from the tag and age memories. A hit needs the scan pass
// only; a miss makes a second pass over the ways to update the ages. Both
// passes are bound by the single read port of the tag and age memories.
// s_ready is low while an address is in work, so a new address is taken
// only after the current one has been handed to the output register.
// After reset the valid memory is cleared one set per cycle, all SETS (64)
// sets in turn; s_ready stays low meanwhile.
// Results sit in an output register: a new address is taken while a result
// waits, but the next result is held back until m_ready takes the first.
// ----------------------------------------------------------------------------
module set_assoc_tag_lookup_fifo_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [31:0]            s_address,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit,
    output logic [3:0]             m_way,
    output logic                   m_evicted,
    output logic [19:0]            m_evicted_tag
);

    stlf_pkg::state_t   state_reg, state_next;
    stlf_pkg::set_idx_t clr_cnt_reg, clr_cnt_next;
    stlf_pkg::set_idx_t set_reg, set_next;
    stlf_pkg::tag_t     key_reg, key_next;
    stlf_pkg::cnt_t     cnt_reg, cnt_next;
    logic               pipe_vld_reg, pipe_vld_next;
    stlf_pkg::way_idx_t pipe_way_reg, pipe_way_next;
    stlf_pkg::way_idx_t vict_reg, vict_next;
    logic               res_hit_reg, res_hit_next;
    logic               res_ev_reg, res_ev_next;
    stlf_pkg::tag_t     res_tag_reg, res_tag_next;

    logic               m_valid_reg;
    logic               m_hit_reg;
    stlf_pkg::way_t     m_way_reg;
    logic               m_ev_reg;
    stlf_pkg::tag_t     m_evtag_reg;
    logic               out_load;

    // Memory ports.
    logic               ent_rd_en;
    stlf_pkg::entry_t   ent_rd_addr;
    logic               tag_wr_en;
    stlf_pkg::entry_t   tag_wr_addr;
    stlf_pkg::tag_t     tag_rd_data;
    logic               age_wr_en;
    stlf_pkg::entry_t   age_wr_addr;
    stlf_pkg::age_t     age_wr_data;
    stlf_pkg::age_t     age_rd_data;
    logic               vld_wr_en;
    stlf_pkg::set_idx_t vld_wr_addr;
    stlf_pkg::row_t     vld_wr_data;
    logic               vld_rd_en;
    stlf_pkg::set_idx_t vld_rd_addr;
    stlf_pkg::row_t     vrow;

    stlf_pkg::scan_step_t step;
    stlf_pkg::scan_res_t  scan_res;
    stlf_pkg::way_idx_t   miss_way;
    logic                 last_way;
    logic                 issue_more;

    // Tag, age and valid memories.
    stlf_ram #(
        .WIDTH (stlf_pkg::TAG_W),
        .DEPTH (stlf_pkg::ENTRIES)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_wr_en),
        .wr_addr (tag_wr_addr),
        .wr_data (key_reg),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (tag_rd_data)
    );

    stlf_ram #(
        .WIDTH (stlf_pkg::AGE_W),
        .DEPTH (stlf_pkg::ENTRIES)
    ) u_age_ram (
        .aclk    (aclk),
        .wr_en   (age_wr_en),
        .wr_addr (age_wr_addr),
        .wr_data (age_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (age_rd_data)
    );

    stlf_ram #(
        .WIDTH (stlf_pkg::WAYS),
        .DEPTH (stlf_pkg::SETS)
    ) u_vld_ram (
        .aclk    (aclk),
        .wr_en   (vld_wr_en),
        .wr_addr (vld_wr_addr),
        .wr_data (vld_wr_data),
        .rd_en   (vld_rd_en),
        .rd_addr (vld_rd_addr),
        .rd_data (vrow)
    );

    // The way arriving from memory feeds the compare unit during the scan.
    assign step.en         = (state_reg == stlf_pkg::ST_SCAN) && pipe_vld_reg;
    assign step.way        = pipe_way_reg;
    assign step.line_valid = vrow[pipe_way_reg];
    assign step.tag        = tag_rd_data;
    assign step.age        = age_rd_data;

    stlf_scan u_scan (
        .aclk    (aclk),
        .step    (step),
        .key_tag (key_reg),
        .res     (scan_res)
    );

    assign last_way   = pipe_vld_reg
                        && (pipe_way_reg == stlf_pkg::way_idx_t'(stlf_pkg::WAYS - 1));
    assign issue_more = (cnt_reg < stlf_pkg::cnt_t'(stlf_pkg::WAYS));
    assign miss_way   = scan_res.inv_found ? scan_res.inv_way : scan_res.min_way;
    assign out_load   = (state_reg == stlf_pkg::ST_RESP) && (!m_valid_reg || m_ready);
    assign s_ready    = (state_reg == stlf_pkg::ST_IDLE);

    // Sequencer: next state, memory controls and result capture.
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        set_next      = set_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        pipe_vld_next = 1'b0;
        pipe_way_next = pipe_way_reg;
        vict_next     = vict_reg;
        res_hit_next  = res_hit_reg;
        res_ev_next   = res_ev_reg;
        res_tag_next  = res_tag_reg;
        ent_rd_en     = 1'b0;
        ent_rd_addr   = {set_reg, cnt_reg[stlf_pkg::WAY_IDX_W-1:0]};
        tag_wr_en     = 1'b0;
        tag_wr_addr   = {set_reg, miss_way};
        age_wr_en     = 1'b0;
        age_wr_addr   = {set_reg, pipe_way_reg};
        age_wr_data   = '0;
        vld_wr_en     = 1'b0;
        vld_wr_addr   = set_reg;
        vld_wr_data   = '0;
        vld_rd_en     = 1'b0;
        vld_rd_addr   = stlf_pkg::addr_set(s_address);
        unique case (state_reg)
            stlf_pkg::ST_CLEAR: begin
                vld_wr_en    = 1'b1;
                vld_wr_addr  = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == stlf_pkg::set_idx_t'(stlf_pkg::SETS - 1)) begin
                    state_next = stlf_pkg::ST_IDLE;
                end
            end
            stlf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    set_next      = stlf_pkg::addr_set(s_address);
                    key_next      = stlf_pkg::addr_tag(s_address);
                    vld_rd_en     = 1'b1;
                    ent_rd_en     = 1'b1;
                    ent_rd_addr   = {stlf_pkg::addr_set(s_address), {stlf_pkg::WAY_IDX_W{1'b0}}};
                    cnt_next      = stlf_pkg::cnt_t'(1);
                    pipe_vld_next = 1'b1;
                    pipe_way_next = '0;
                    state_next    = stlf_pkg::ST_SCAN;
                end
            end
            stlf_pkg::ST_SCAN: begin
                if (issue_more) begin
                    ent_rd_en     = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                    pipe_way_next = cnt_reg[stlf_pkg::WAY_IDX_W-1:0];
                end
                if (last_way) begin
                    state_next = stlf_pkg::ST_DECIDE;
                end
            end
            stlf_pkg::ST_DECIDE: begin
                if (scan_res.hit) begin
                    vict_next    = scan_res.hit_way;
                    res_hit_next = 1'b1;
                    res_ev_next  = 1'b0;
                    res_tag_next = '0;
                    state_next   = stlf_pkg::ST_RESP;
                end else begin
                    vict_next    = miss_way;
                    res_hit_next = 1'b0;
                    res_ev_next  = !scan_res.inv_found;
                    res_tag_next = scan_res.inv_found ? '0 : scan_res.min_tag;
                    tag_wr_en    = 1'b1;
                    vld_wr_en    = 1'b1;
                    vld_wr_data  = vrow | (stlf_pkg::row_t'(1) << miss_way);
                    cnt_next     = '0;
                    state_next   = stlf_pkg::ST_AGE;
                end
            end
            stlf_pkg::ST_AGE: begin
                // Read one age per cycle and write back the previous one.
                if (issue_more) begin
                    ent_rd_en     = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                    pipe_way_next = cnt_reg[stlf_pkg::WAY_IDX_W-1:0];
                end
                if (pipe_vld_reg) begin
                    if (pipe_way_reg == vict_reg) begin
                        age_wr_en   = 1'b1;
                        age_wr_data = stlf_pkg::age_t'(stlf_pkg::WAYS - 1);
                    end else if (vrow[pipe_way_reg]) begin
                        age_wr_en   = 1'b1;
                        age_wr_data = (age_rd_data == '0) ? '0 : age_rd_data - 1'b1;
                    end
                end
                if (last_way) begin
                    state_next = stlf_pkg::ST_RESP;
                end
            end
            stlf_pkg::ST_RESP: begin
                if (out_load) begin
                    state_next = stlf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stlf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= stlf_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            pipe_vld_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            pipe_vld_reg <= pipe_vld_next;
            cnt_reg      <= cnt_next;
        end
    end

    // Working registers of the current address.
    always_ff @(posedge aclk) begin
        set_reg      <= set_next;
        key_reg      <= key_next;
        pipe_way_reg <= pipe_way_next;
        vict_reg     <= vict_next;
        res_hit_reg  <= res_hit_next;
        res_ev_reg   <= res_ev_next;
        res_tag_reg  <= res_tag_next;
    end

    // Output register of the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_hit_reg   <= res_hit_reg;
            m_way_reg   <= stlf_pkg::way_t'(vict_reg);
            m_ev_reg    <= res_ev_reg;
            m_evtag_reg <= res_tag_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_way         = m_way_reg;
    assign m_evicted     = m_ev_reg;
    assign m_evicted_tag = m_evtag_reg;

    // A hit never evicts a line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted))
        else $error("hit reported together with an eviction");

    // The evicted tag reads zero unless a line was replaced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted) |-> (m_evicted_tag == '0))
        else $error("evicted tag nonzero without eviction");

    // The reported way lies inside the set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_way < stlf_pkg::way_t'(stlf_pkg::WAYS - 1)
                     || m_way == stlf_pkg::way_t'(stlf_pkg::WAYS - 1)))
        else $error("reported way outside the set");

    // After an address transfer the engine is busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second address taken while busy");

    // Ages and tags are written only while an address is in work.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (age_wr_en || tag_wr_en) |-> !s_ready)
        else $error("tag or age memory written while idle");

endmodule
